/* src/alrp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the two-track looper.
// Used by alrp_store, alrp_wrap and audio_looper_record_play_unit.

package alrp_pkg;

   // Geometry
   localparam int TRACK_COUNT = 2;
   localparam int LOOP_LEN    = 16384;
   localparam int TRACK_W     = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
   localparam int POS_W       = $clog2(LOOP_LEN);
   localparam int LEN_W       = $clog2(LOOP_LEN + 1);
   localparam int STORE_DEPTH = TRACK_COUNT * LOOP_LEN;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(LEN_W);
   localparam int SH_W        = 2 * LEN_W - 1;

   // Sample and knob widths
   localparam int SMP_W  = 12;
   localparam int D8_W   = 8;
   localparam int CMD_W  = 3;
   localparam int PROD_W = SMP_W + D8_W;

   // 12-bit to 8-bit reduction: floor(x * 255 / 4095), with 1/4095 taken as
   // 4097 / 2^24 and one correction step
   localparam int SMP_SCALE   = 255;
   localparam int SMP_DIV     = 4095;
   localparam int RECIP       = 4097;
   localparam int RECIP_SHIFT = 24;
   localparam int RQ_W        = 32;

   // Volume is an unsigned Q1.11 gain
   localparam int VOL_SHIFT = 11;

   localparam logic [SMP_W-1:0] FAST_THR_RST = 12'd3000;
   localparam logic [SMP_W-1:0] NORM_THR_RST = 12'd1500;

   localparam logic CSR_FAST_THR = 1'b0;
   localparam logic CSR_NORM_THR = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE = 3'd0,
      CMD_RECORD = 3'd1,
      CMD_PLAY   = 3'd2,
      CMD_UP     = 3'd3,
      CMD_DOWN   = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      STEP_NORMAL = 2'd0,
      STEP_DOUBLE = 2'd2,
      STEP_STALL  = 2'd3
   } step_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MIX,
      ST_MOD,
      ST_SCALE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [ADDR_W-1:0] addr;
      logic [D8_W-1:0]   wr_data;
   } store_req_type;

   typedef struct packed {
      logic             start;
      logic [LEN_W-1:0] dividend;
      logic [LEN_W-1:0] divisor;
   } wrap_req_type;

   typedef struct packed {
      logic             done;
      logic [LEN_W-1:0] remainder;
   } wrap_rsp_type;

endpackage

/* src/alrp_store.sv */
`timescale 1ns / 1ps
// Sample store: one single-port memory holding every track's loop.
// Depends on alrp_pkg for depth, widths and the request struct.

module alrp_store (
   input  logic                    clock,
   input  alrp_pkg::store_req_type store_req,
   output logic [7:0]              rd_data
);
   import alrp_pkg::*;

   logic [D8_W-1:0] store_ff [STORE_DEPTH];
   logic [D8_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         store_ff[store_req.addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_data_ff <= store_ff[store_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/alrp_wrap.sv */
`timescale 1ns / 1ps
// Shared remainder unit: restoring shift-subtract, one quotient bit a cycle.
// Depends on alrp_pkg for widths and the request and response structs.

module alrp_wrap (
   input  logic                   clock,
   input  logic                   reset,
   input  alrp_pkg::wrap_req_type wrap_req,
   output alrp_pkg::wrap_rsp_type wrap_rsp
);
   import alrp_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [LEN_W-1:0] div_ff, div_in;
   logic [SH_W-1:0]  shifted;

   always_comb begin
      shifted = SH_W'(div_ff) << cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (wrap_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(LEN_W - 1);
         rem_in  = wrap_req.dividend;
         div_in  = wrap_req.divisor;
      end else if (busy_ff) begin
         // subtract the shifted divisor where it fits
         if (SH_W'(rem_ff) >= shifted) begin
            rem_in = rem_ff - shifted[LEN_W-1:0];
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign wrap_rsp.done      = done_ff;
   assign wrap_rsp.remainder = rem_ff;

endmodule

/* src/audio_looper_record_play_unit.sv */
`timescale 1ns / 1ps
// Top level of the two-track looper: sequencer, track state and datapath.
// Depends on alrp_pkg, alrp_store and alrp_wrap.
//
// Usage:
//  - req channel: one beat per item. req_tuser carries the command, req_tdata
//    the audio sample, speed knob and volume knob. Only a sample command
//    (code 0) gives a response beat; every other command only updates state.
//  - rsp channel: the 8-bit output sample and the record and play lamps of the
//    selected track, held in an output register until taken.
//  - csr channel: thresholds for the speed knob, always ready, one write a beat.
//  - A sample beat runs through decode, mix, scale and emit, and the response
//    is registered at emit; a new beat is taken only after the item returns to
//    idle. When the play position runs past the loop end, a mod step waits on
//    the shared remainder unit (one quotient bit a cycle over 15 bits).
//    Other commands go from decode straight back to idle.
//  - req_tready is low while an item is in flight. While the receiver stalls,
//    one response waits in the output register and the next item still runs
//    up to its emit step, where it holds until the register frees.
//  - Reset clears the track flags, loop lengths, position, speed state and
//    thresholds. The sample store is not cleared; a track only reads back
//    what it recorded.

module audio_looper_record_play_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // audio_sample[11:0], speed_knob[23:12],
                                   // volume_knob[35:24], zero[39:36]
   input  logic [2:0]  req_tuser,  // command[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // dac_out[7:0], record_led[8], play_led[9],
                                   // zero[15:10]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [11:0] csr_data
);
   import alrp_pkg::*;

   state_type state_ff, state_in;

   // captured request
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [SMP_W-1:0] knob_ff, knob_in;
   logic [SMP_W-1:0] vol_ff, vol_in;

   // configuration
   logic [SMP_W-1:0] fast_thr_ff, fast_thr_in;
   logic [SMP_W-1:0] norm_thr_ff, norm_thr_in;

   // track state
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [LEN_W-1:0]       len_ff [TRACK_COUNT];
   logic [LEN_W-1:0]       len_in [TRACK_COUNT];
   logic [TRACK_COUNT-1:0] rec_ff, rec_in;
   logic [TRACK_COUNT-1:0] has_ff, has_in;
   logic [TRACK_COUNT-1:0] play_ff, play_in;
   step_type               step_ff, step_in;
   logic                   armed_ff, armed_in;
   logic [TRACK_W-1:0]     track_ff, track_in;

   // datapath
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [D8_W-1:0]   q0_ff, q0_in;
   logic [D8_W-1:0]   mix_ff, mix_in;
   logic              active_ff, active_in;
   logic [D8_W-1:0]   dac_ff, dac_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   store_req_type    store_req;
   logic [D8_W-1:0]  store_rd;
   wrap_req_type     wrap_req;
   wrap_rsp_type     wrap_rsp;

   // decisions shared by the sequencer and the datapath
   logic             cur_rec, cur_has, cur_play;
   logic [LEN_W-1:0] limit;
   logic             mix_move;
   logic [LEN_W-1:0] next_sum;
   logic             emit_free;
   logic [ADDR_W-1:0] cur_addr;

   alrp_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (store_rd)
   );

   alrp_wrap u_wrap (
      .clock    (clock),
      .reset    (reset),
      .wrap_req (wrap_req),
      .wrap_rsp (wrap_rsp)
   );

   always_comb begin
      cur_rec  = rec_ff[track_ff];
      cur_has  = has_ff[track_ff];
      cur_play = play_ff[track_ff];
      limit    = len_ff[track_ff];
      if (limit == '0 || limit > LEN_W'(LOOP_LEN)) begin
         limit = LEN_W'(LOOP_LEN);
      end
      cur_addr = ADDR_W'(ADDR_W'(track_ff) * ADDR_W'(LOOP_LEN)) + ADDR_W'(pos_ff);
      // a recording track always steps normal; a stall step holds the position
      mix_move = (cur_rec || cur_play) && (cur_rec || step_ff != STEP_STALL);
      if (!cur_rec && step_ff == STEP_DOUBLE) begin
         next_sum = LEN_W'(pos_ff) + LEN_W'(2);
      end else begin
         next_sum = LEN_W'(pos_ff) + LEN_W'(1);
      end
      emit_free = !rsp_valid_ff || rsp_tready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = (cmd_ff == CMD_SAMPLE) ? ST_MIX : ST_IDLE;
         end
         ST_MIX: begin
            state_in = (mix_move && next_sum >= limit) ? ST_MOD : ST_SCALE;
         end
         ST_MOD: begin
            if (wrap_rsp.done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready        = 1'b0;
      store_req.rd_en   = 1'b0;
      store_req.wr_en   = 1'b0;
      store_req.addr    = cur_addr;
      store_req.wr_data = '0;
      wrap_req.start    = 1'b0;
      wrap_req.dividend = next_sum;
      wrap_req.divisor  = limit;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_DECODE: begin
            store_req.rd_en = (cmd_ff == CMD_SAMPLE);
         end
         ST_MIX: begin
            store_req.wr_en   = cur_rec;
            store_req.wr_data = mix_in;
            wrap_req.start    = mix_move && next_sum >= limit;
         end
         ST_MOD, ST_SCALE, ST_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   // datapath and track state
   always_comb begin : datapath
      logic [PROD_W-1:0] rem;
      logic [D8_W-1:0]   d8;
      logic [D8_W:0]     mix_sum;
      logic [RQ_W-1:0]   recip_prod;
      logic [PROD_W-1:0] vol_prod;

      cmd_in      = cmd_ff;
      knob_in     = knob_ff;
      vol_in      = vol_ff;
      fast_thr_in = fast_thr_ff;
      norm_thr_in = norm_thr_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      rec_in      = rec_ff;
      has_in      = has_ff;
      play_in     = play_ff;
      step_in     = step_ff;
      armed_in    = armed_ff;
      track_in    = track_ff;
      prod_in     = prod_ff;
      q0_in       = q0_ff;
      mix_in      = mix_ff;
      active_in   = active_ff;
      dac_in      = dac_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      recip_prod = RQ_W'(prod_ff) * RQ_W'(RECIP);
      rem = prod_ff - PROD_W'(PROD_W'(q0_ff) * PROD_W'(SMP_DIV));
      d8  = q0_ff + ((rem >= PROD_W'(SMP_DIV)) ? D8_W'(1) : D8_W'(0));
      mix_sum  = (D8_W + 1)'(d8) + (D8_W + 1)'(store_rd);
      vol_prod = PROD_W'(mix_ff) * PROD_W'(vol_ff);

      if (csr_valid) begin
         unique case (csr_index)
            CSR_FAST_THR: fast_thr_in = csr_data;
            CSR_NORM_THR: norm_thr_in = csr_data;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in  = req_tuser;
               knob_in = req_tdata[23:12];
               vol_in  = req_tdata[35:24];
               // first half of the 12-to-8 bit reduction
               prod_in = PROD_W'(PROD_W'(req_tdata[11:0]) * PROD_W'(SMP_SCALE));
            end
         end

         ST_DECODE: begin
            case (cmd_ff)
               CMD_SAMPLE: begin
                  if (knob_ff > fast_thr_ff) begin
                     step_in = STEP_DOUBLE;
                  end else if (knob_ff > norm_thr_ff) begin
                     step_in = STEP_NORMAL;
                  end else if (armed_ff) begin
                     step_in  = STEP_STALL;
                     armed_in = 1'b0;
                  end
                  q0_in     = recip_prod[RECIP_SHIFT +: D8_W];
                  active_in = cur_rec || cur_play;
               end
               CMD_RECORD: begin
                  if (cur_rec) begin
                     if (!cur_has) begin
                        len_in[track_ff] = (pos_ff == '0) ? LEN_W'(1) : LEN_W'(pos_ff);
                     end
                     rec_in[track_ff]  = 1'b0;
                     has_in[track_ff]  = 1'b1;
                     play_in[track_ff] = 1'b1;
                     pos_in            = '0;
                  end else begin
                     if (!cur_play) begin
                        has_in[track_ff] = 1'b0;
                        len_in[track_ff] = LEN_W'(LOOP_LEN);
                        pos_in           = '0;
                     end
                     rec_in[track_ff] = 1'b1;
                  end
               end
               CMD_PLAY: begin
                  if (cur_has) begin
                     play_in[track_ff] = !cur_play;
                  end
               end
               CMD_UP: begin
                  if (track_ff != '0) begin
                     track_in = track_ff - 1'b1;
                  end
               end
               CMD_DOWN: begin
                  if (32'(track_ff) + 1 < TRACK_COUNT) begin
                     track_in = track_ff + 1'b1;
                  end
               end
               CMD_CLEAR: begin
                  for (int i = 0; i < TRACK_COUNT; i++) begin
                     len_in[i] = LEN_W'(LOOP_LEN);
                  end
                  rec_in   = '0;
                  has_in   = '0;
                  play_in  = '0;
                  pos_in   = '0;
                  step_in  = STEP_NORMAL;
                  track_in = '0;
               end
               default: begin
                  // unused command codes: drop
               end
            endcase
         end

         ST_MIX: begin
            mix_in = d8;
            if (cur_play && cur_has && !cur_rec) begin
               mix_in = mix_sum[D8_W] ? '1 : mix_sum[D8_W-1:0];
            end
            if (active_ff) begin
               if (cur_rec) begin
                  step_in = STEP_NORMAL;
               end
               if (!cur_rec && step_ff == STEP_STALL) begin
                  step_in = STEP_NORMAL;
               end else begin
                  if (cur_rec || step_ff != STEP_DOUBLE) begin
                     armed_in = 1'b1;
                  end
                  if (next_sum < limit) begin
                     pos_in = next_sum[POS_W-1:0];
                  end
               end
            end
         end

         ST_MOD: begin
            if (wrap_rsp.done) begin
               pos_in = wrap_rsp.remainder[POS_W-1:0];
            end
         end

         ST_SCALE: begin
            // a first take that wrapped to the start ends here
            if (active_ff && pos_ff == '0 && cur_rec && !cur_has) begin
               rec_in[track_ff]  = 1'b0;
               has_in[track_ff]  = 1'b1;
               play_in[track_ff] = 1'b1;
               pos_in            = '0;
            end
            dac_in = vol_prod[PROD_W-1] ? '1 : vol_prod[VOL_SHIFT +: D8_W];
         end

         ST_EMIT: begin
            if (emit_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0, cur_play, cur_rec, dac_ff};
            end
         end

         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fast_thr_ff  <= FAST_THR_RST;
         norm_thr_ff  <= NORM_THR_RST;
         pos_ff       <= '0;
         for (int i = 0; i < TRACK_COUNT; i++) begin
            len_ff[i] <= LEN_W'(LOOP_LEN);
         end
         rec_ff       <= '0;
         has_ff       <= '0;
         play_ff      <= '0;
         step_ff      <= STEP_NORMAL;
         armed_ff     <= 1'b0;
         track_ff     <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fast_thr_ff  <= fast_thr_in;
         norm_thr_ff  <= norm_thr_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         rec_ff       <= rec_in;
         has_ff       <= has_in;
         play_ff      <= play_in;
         step_ff      <= step_in;
         armed_ff     <= armed_in;
         track_ff     <= track_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      knob_ff     <= knob_in;
      vol_ff      <= vol_in;
      prod_ff     <= prod_in;
      q0_ff       <= q0_in;
      mix_ff      <= mix_in;
      dac_ff      <= dac_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
